// File: rtl/clt_pkg.sv
// Shared types and character constants for the command line tokenizer.
package clt_pkg;

    // Tokenizer phase
    typedef enum logic [1:0] {
        PH_NAME  = 2'd0,
        PH_GAP   = 2'd1,
        PH_TOKEN = 2'd2
    } phase_t;

    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_TAB       = 8'h09;
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BACKSLASH = 8'h5C;

    localparam logic [7:0] TOKEN_MAX = 8'd255;

    // One result request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic [7:0] token_number;
        logic       line_done;
    } result_t;

endpackage

// File: rtl/command_line_tokenizer_unit.sv
// Command line tokenizer: one byte per request in, token bytes and markers out.
// Output: each result is registered in the result queue and is driven on the m_ side from slot 0.
// Throughput: one byte per cycle while m_ready is high and each byte gives at most one
//   result; a byte that gives two results (held backslash ahead of another result)
//   holds s_ready low until the two-entry result queue has drained an entry.
// Reset: synchronous active-low aresetn clears the phase, flags, token counter and
//   result queue; the block is ready once reset has emptied the result queue.
module command_line_tokenizer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_line_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_token_end,
    output logic [7:0] m_token_number,
    output logic       m_line_done
);

    // Tokenizer state
    clt_pkg::phase_t phase_reg, phase_next;
    logic            quoted_reg, quoted_next;
    logic            held_reg, held_next;
    logic [7:0]      count_reg, count_next;

    // Result queue, slot 0 drives the output
    clt_pkg::result_t slot0_reg, slot0_next;
    clt_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]       fill_reg, fill_next;

    logic             in_fire, out_fire;
    logic [1:0]       push_n;
    clt_pkg::result_t res0, res1;
    logic             is_sep;
    logic [7:0]       count_inc;

    assign m_valid   = (fill_reg != 2'd0);
    assign out_fire  = m_valid && m_ready;
    assign s_ready   = (fill_reg == 2'd0) || ((fill_reg == 2'd1) && m_ready);
    assign in_fire   = s_valid && s_ready;

    assign is_sep    = (s_ch == clt_pkg::CHR_SPACE) || (s_ch == clt_pkg::CHR_TAB);
    assign count_inc = (count_reg == clt_pkg::TOKEN_MAX) ? count_reg : count_reg + 8'd1;

    assign m_out_byte     = slot0_reg.out_byte;
    assign m_byte_valid   = slot0_reg.byte_valid;
    assign m_token_end    = slot0_reg.token_end;
    assign m_token_number = slot0_reg.token_number;
    assign m_line_done    = slot0_reg.line_done;

    // Per-byte decision: results and next state
    always_comb begin
        logic             tb_n;
        clt_pkg::result_t tb_res;
        logic [7:0]       num;
        logic             q;

        phase_next  = phase_reg;
        quoted_next = quoted_reg;
        held_next   = held_reg;
        count_next  = count_reg;
        push_n      = 2'd0;
        res0        = '0;
        res1        = '0;
        tb_n        = 1'b0;
        tb_res      = '0;
        num         = count_reg;
        q           = quoted_reg;

        if (s_line_end) begin
            res0.token_number = count_reg;
            res1.token_number = count_reg;
            push_n            = 2'd1;
            case (phase_reg)
                clt_pkg::PH_NAME: begin
                    res0.token_end = 1'b1;
                    res0.line_done = 1'b1;
                end
                clt_pkg::PH_TOKEN: begin
                    if (held_reg) begin
                        res0.out_byte   = clt_pkg::CHR_BACKSLASH;
                        res0.byte_valid = 1'b1;
                        res1.token_end  = 1'b1;
                        res1.line_done  = 1'b1;
                        push_n          = 2'd2;
                    end else begin
                        res0.token_end = 1'b1;
                        res0.line_done = 1'b1;
                    end
                end
                default: begin
                    res0.line_done = 1'b1;
                end
            endcase
            phase_next  = clt_pkg::PH_NAME;
            quoted_next = 1'b0;
            held_next   = 1'b0;
            count_next  = '0;
        end else begin
            case (phase_reg)
                clt_pkg::PH_NAME: begin
                    res0.token_number = count_reg;
                    push_n            = 2'd1;
                    if (is_sep) begin
                        res0.token_end = 1'b1;
                        phase_next     = clt_pkg::PH_GAP;
                    end else begin
                        res0.out_byte   = s_ch;
                        res0.byte_valid = 1'b1;
                    end
                end
                clt_pkg::PH_TOKEN: begin
                    num       = count_reg;
                    held_next = 1'b0;
                    if (held_reg && (s_ch == clt_pkg::CHR_QUOTE)) begin
                        // escaped quote: emit it, quoting unchanged
                        res0.out_byte     = clt_pkg::CHR_QUOTE;
                        res0.byte_valid   = 1'b1;
                        res0.token_number = num;
                        push_n            = 2'd1;
                    end else begin
                        // token byte handling, shared below
                        tb_n = 1'b1;
                    end
                end
                default: begin
                    if (!is_sep) begin
                        count_next = count_inc;
                        num        = count_inc;
                        phase_next = clt_pkg::PH_TOKEN;
                        q          = 1'b0;
                        held_next  = 1'b0;
                        tb_n       = 1'b1;
                    end
                end
            endcase

            // Byte inside a later token
            if (tb_n) begin
                logic emit;
                emit                = 1'b0;
                tb_res              = '0;
                tb_res.token_number = num;
                quoted_next         = q;
                if (is_sep) begin
                    emit = 1'b1;
                    if (q) begin
                        tb_res.out_byte   = s_ch;
                        tb_res.byte_valid = 1'b1;
                    end else begin
                        tb_res.token_end = 1'b1;
                        phase_next       = clt_pkg::PH_GAP;
                        quoted_next      = 1'b0;
                    end
                end else if (s_ch == clt_pkg::CHR_QUOTE) begin
                    quoted_next = ~q;
                end else if (s_ch == clt_pkg::CHR_BACKSLASH) begin
                    held_next = 1'b1;
                end else begin
                    emit              = 1'b1;
                    tb_res.out_byte   = s_ch;
                    tb_res.byte_valid = 1'b1;
                end

                // a released backslash goes ahead of this byte's result
                if ((phase_reg == clt_pkg::PH_TOKEN) && held_reg) begin
                    res0.out_byte     = clt_pkg::CHR_BACKSLASH;
                    res0.byte_valid   = 1'b1;
                    res0.token_number = num;
                    res1              = tb_res;
                    push_n            = emit ? 2'd2 : 2'd1;
                end else begin
                    res0   = tb_res;
                    push_n = emit ? 2'd1 : 2'd0;
                end
            end
        end
    end

    // Result queue update: pop from the front, append new results
    always_comb begin
        logic [1:0]       base;
        logic [1:0]       add;
        clt_pkg::result_t q0;
        base = fill_reg - {1'b0, out_fire};
        add  = in_fire ? push_n : 2'd0;
        q0   = out_fire ? slot1_reg : slot0_reg;
        case (base)
            2'd0: begin
                slot0_next = res0;
                slot1_next = res1;
            end
            2'd1: begin
                slot0_next = q0;
                slot1_next = res0;
            end
            default: begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        fill_next = base + add;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= clt_pkg::PH_NAME;
            quoted_reg <= 1'b0;
            held_reg   <= 1'b0;
            count_reg  <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (in_fire) begin
                phase_reg  <= phase_next;
                quoted_reg <= quoted_next;
                held_reg   <= held_next;
                count_reg  <= count_next;
            end
        end
    end

    // Queue payload
    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("result queue overfilled");

    a_line_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_line_end) |=> (phase_reg == clt_pkg::PH_NAME) && (count_reg == 8'd0)
            && !held_reg && !quoted_reg)
        else $error("state not cleared after line end");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !s_line_end) |=> (count_reg == $past(count_reg))
            || (count_reg == $past(count_reg) + 8'd1))
        else $error("token counter jumped");

    a_held_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> (phase_reg == clt_pkg::PH_TOKEN))
        else $error("backslash held outside a token");

    a_last_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_done) |-> !m_byte_valid)
        else $error("line done carries a byte");

endmodule
